### sv/lars_pkg.sv
// Shared types and constants for the row-streaming life automaton step.
// Used by lars_cell, lars_outq and life_automaton_row_step.
package lars_pkg;

    localparam int ROW_BITS   = 64;
    localparam int WIDTH_BITS = 7;
    localparam int COUNT_BITS = 4;
    localparam int NBR_COUNT  = 8;

    localparam logic [COUNT_BITS-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [COUNT_BITS-1:0] SURVIVE_COUNT = 4'd2;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd32;

    // Result queue: room for two results behind the one being shown.
    localparam int QUEUE_DEPTH = 3;
    localparam int QIDX_BITS   = 2;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_cells;
        logic                grid_done;
    } result_t;

    // What one accepted row pushes into the result queue.
    typedef struct packed {
        logic [QIDX_BITS-1:0] count;
        result_t              first;
        result_t              second;
    } push_t;

endpackage

### sv/lars_cell.sv
// One lane: the B3/S23 rule for a single cell from its eight neighbors.
// Depends on lars_pkg for the count width and the rule constants.
module lars_cell
(
    input  logic [lars_pkg::NBR_COUNT-1:0] nbrs,
    input  logic                           alive,
    input  logic                           lane_on,
    output logic                           next_alive
);

    logic [lars_pkg::COUNT_BITS-1:0] count;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < lars_pkg::NBR_COUNT; i++)
        begin
            count = count + lars_pkg::COUNT_BITS'(nbrs[i]);
        end
    end

    assign next_alive = lane_on && ((count == lars_pkg::BIRTH_COUNT) ||
                                    (alive && (count == lars_pkg::SURVIVE_COUNT)));

endmodule

### sv/lars_row.sv
// One full row of lanes: next generation of the middle row of three.
// Instantiates lars_cell once per column.
module lars_row #(
    parameter int LANES = 64
)
(
    input  logic [LANES-1:0] above,
    input  logic [LANES-1:0] here,
    input  logic [LANES-1:0] below,
    input  logic [LANES-1:0] mask,
    output logic [LANES-1:0] result
);

    // Masked rows padded with a dead column on each side.
    logic [LANES+1:0] a_pad;
    logic [LANES+1:0] h_pad;
    logic [LANES+1:0] b_pad;

    assign a_pad = {1'b0, above & mask, 1'b0};
    assign h_pad = {1'b0, here  & mask, 1'b0};
    assign b_pad = {1'b0, below & mask, 1'b0};

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        lars_cell u_cell
        (
            .nbrs       ({a_pad[k+2:k], h_pad[k+2], h_pad[k], b_pad[k+2:k]}),
            .alive      (h_pad[k+1]),
            .lane_on    (mask[k]),
            .next_alive (result[k])
        );
    end

endmodule

### sv/lars_outq.sv
// Three-entry result queue that takes up to two results per cycle.
// Depends on lars_pkg for result_t and push_t.
module lars_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  lars_pkg::push_t   push,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output lars_pkg::result_t head
);

    lars_pkg::result_t ent_reg [lars_pkg::QUEUE_DEPTH];
    lars_pkg::result_t ent_next [lars_pkg::QUEUE_DEPTH];
    logic [lars_pkg::QIDX_BITS-1:0] count_reg;
    logic [lars_pkg::QIDX_BITS-1:0] count_next;
    logic [lars_pkg::QIDX_BITS-1:0] base;
    logic                           pop;

    assign out_valid = (count_reg != '0);
    assign has_room  = (count_reg < lars_pkg::QIDX_BITS'(lars_pkg::QUEUE_DEPTH - 1));
    assign head      = ent_reg[0];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        base = count_reg - lars_pkg::QIDX_BITS'(pop);
        for (int i = 0; i < lars_pkg::QUEUE_DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < lars_pkg::QUEUE_DEPTH - 1; i++)
            begin
                ent_next[i] = ent_reg[i+1];
            end
        end
        if (push.count != '0)
        begin
            ent_next[base] = push.first;
        end
        if (push.count == lars_pkg::QIDX_BITS'(2))
        begin
            ent_next[base + lars_pkg::QIDX_BITS'(1)] = push.second;
        end
        count_next = base + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lars_pkg::QUEUE_DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

endmodule

### sv/life_automaton_row_step.sv
// A result word is written into the registered result queue when the row that releases it is accepted.
// Throughput: one row per clock while the result queue has room; a bottom row that releases
// two results pushes two words, and the result queue drains one word per cycle.
// Reset (rst_n low, asynchronous) empties the held rows and the result queue and sets
// grid_width to 32; the block is ready to accept right after reset.
// Depends on lars_pkg, lars_row and lars_outq.
module life_automaton_row_step #(
    parameter int MAX_WIDTH = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration: grid width, written while the block is idle.
    input  logic                               cfg_we,
    input  logic [lars_pkg::WIDTH_BITS-1:0]    cfg_data,

    // Input rows of the current generation.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lars_pkg::ROW_BITS-1:0]      row_cells,
    input  logic                               final_row,

    // Output rows of the next generation.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lars_pkg::ROW_BITS-1:0]      next_cells,
    output logic                               grid_done
);

    // Configured width; columns at and above it are dead.
    logic [lars_pkg::WIDTH_BITS-1:0] grid_width_reg;

    // Two rows held back: the row above the newest one, and the one above that.
    logic [MAX_WIDTH-1:0] upper_reg;
    logic [MAX_WIDTH-1:0] middle_reg;
    logic                 held_reg;     // at least one row of this grid has arrived

    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] row_m;
    logic [MAX_WIDTH-1:0] now_result;
    logic [MAX_WIDTH-1:0] last_above;
    logic [MAX_WIDTH-1:0] last_result;
    logic                 accept;

    lars_pkg::push_t   push;
    lars_pkg::result_t head;

    // Lane k is live when its column lies below the configured width. Lanes only
    // exist up to MAX_WIDTH, which gives the min() against the width for free.
    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_mask
        assign mask[k] = (lars_pkg::WIDTH_BITS'(k) < grid_width_reg);
    end

    assign row_m  = row_cells[MAX_WIDTH-1:0] & mask;
    assign accept = in_valid && in_ready;

    // First lane bank: the next generation of the middle row, with the arriving
    // row below it. It only yields a word once a row is already held.
    lars_row #(
        .LANES (MAX_WIDTH)
    ) u_row_now
    (
        .above  (upper_reg),
        .here   (middle_reg),
        .below  (row_m),
        .mask   (mask),
        .result (now_result)
    );

    // Second lane bank: the bottom row's own next generation, with a dead row
    // below. Above it sits the held middle row, or a dead row for a one-row grid.
    assign last_above = held_reg ? middle_reg : '0;

    lars_row #(
        .LANES (MAX_WIDTH)
    ) u_row_last
    (
        .above  (last_above),
        .here   (row_m),
        .below  ('0),
        .mask   (mask),
        .result (last_result)
    );

    // Merge the two banks into the words this row pushes, in output order.
    always_comb
    begin
        push.count             = '0;
        push.first.next_cells  = lars_pkg::ROW_BITS'(last_result);
        push.first.grid_done   = 1'b1;
        push.second.next_cells = lars_pkg::ROW_BITS'(last_result);
        push.second.grid_done  = 1'b1;
        if (held_reg)
        begin
            push.first.next_cells = lars_pkg::ROW_BITS'(now_result);
            push.first.grid_done  = 1'b0;
        end
        if (accept)
        begin
            push.count = lars_pkg::QIDX_BITS'(held_reg) + lars_pkg::QIDX_BITS'(final_row);
        end
    end

    // The queue keeps room for two words, so input acceptance never depends on
    // out_ready in the same cycle.
    lars_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign next_cells = head.next_cells;
    assign grid_done  = head.grid_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= lars_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            grid_width_reg <= cfg_data;
        end
    end

    // Row window update. The bottom row closes the grid and clears the window,
    // so the next accepted row starts a fresh grid under a dead row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= '0;
            middle_reg <= '0;
            held_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (final_row)
            begin
                upper_reg  <= '0;
                middle_reg <= '0;
                held_reg   <= 1'b0;
            end
            else
            begin
                upper_reg  <= held_reg ? middle_reg : '0;
                middle_reg <= row_m;
                held_reg   <= 1'b1;
            end
        end
    end

endmodule
